@@ rtl/gda_pkg.sv @@
// Shared widths, calendar constants, lookup functions and payload structs
// for the Gregorian date unit. Used by gda_fwd, gda_inv and the top level.
// No dependencies.
package gda_pkg;

    // Field widths
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned OFFSET_W = 21;
    localparam int unsigned EPOCH_W  = 23;
    localparam int unsigned WDAY_W   = 3;
    localparam int unsigned YDAY_W   = 9;
    localparam int unsigned MLEN_W   = 5;

    // Day count biased so that 0000-03-01 of the era before year 0 is zero.
    localparam int unsigned CNT_W = 22;

    localparam int unsigned MONTHS = 12;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MON_JAN    = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MON_DEC    = 4'd12;
    localparam logic [CNT_W-1:0]   CNT_MIN    = 22'd146037;
    localparam logic [CNT_W-1:0]   CNT_MAX    = 22'd3798461;
    localparam logic [CNT_W-1:0]   ERA_DAYS   = 22'd146097;
    localparam logic [EPOCH_W-1:0] EPOCH_BIAS = 23'd865565;

    // Results that depend only on the input date
    typedef struct packed {
        logic signed [EPOCH_W-1:0] epoch_days;
        logic [WDAY_W-1:0]         weekday;
        logic [YDAY_W-1:0]         year_day;
        logic                      leap_year;
        logic [MLEN_W-1:0]         month_length;
    } t_date_info;

    // The shifted calendar date
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               out_of_range;
    } t_shift_date;

    // Days in month m (1 = January).
    function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [MLEN_W-1:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the year before the first of month m (1 = January), common year.
    function automatic logic [YDAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [YDAY_W-1:0] days;
        unique case (m)
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // Days before month mp of a year that starts in March (mp 0 = March).
    function automatic logic [YDAY_W-1:0] mar_cum(input logic [MONTH_W-1:0] mp);
        logic [YDAY_W-1:0] days;
        unique case (mp)
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

@@ rtl/gda_fwd.sv @@
// Date to day count: three pipeline stages that clamp the date, find the
// leap flag, ordinal day, biased day count, weekday and the shifted count.
// Depends on gda_pkg.
module gda_fwd
    import gda_pkg::*;
(
    input  logic                       i_clk,
    input  logic [2:0]                 i_load,
    input  logic [YEAR_W-1:0]          i_year,
    input  logic [MONTH_W-1:0]         i_month,
    input  logic [DAY_W-1:0]           i_day,
    input  logic signed [OFFSET_W-1:0] i_day_offset,
    output logic [CNT_W-1:0]           o_count,
    output logic                       o_out_of_range,
    output t_date_info                 o_info
);

    // Stage 1: clamp year and month, divide the year by 100, leap flag
    logic [YEAR_W-1:0]          n_s1_year, r_s1_year;
    logic [MONTH_W-1:0]         n_s1_month, r_s1_month;
    logic [DAY_W-1:0]           r_s1_day;
    logic signed [OFFSET_W-1:0] r_s1_off;
    logic [6:0]                 n_s1_hund, r_s1_hund;
    logic [6:0]                 n_s1_hrem, r_s1_hrem;
    logic                       n_s1_leap, r_s1_leap;
    logic [21:0]                s1_prod;
    logic [6:0]                 s1_qest;
    logic [YEAR_W-1:0]          s1_rest;

    always_comb begin
        n_s1_year = (i_year > YEAR_MAX) ? YEAR_MAX : i_year;
        if (i_month < MON_JAN) begin
            n_s1_month = MON_JAN;
        end else if (i_month > MON_DEC) begin
            n_s1_month = MON_DEC;
        end else begin
            n_s1_month = i_month;
        end
    end

    // Reciprocal estimate of year / 100 is exact or one low; one correction.
    assign s1_prod = 22'(n_s1_year) * 22'd163;
    assign s1_qest = s1_prod[20:14];
    assign s1_rest = n_s1_year - 14'(s1_qest) * 14'd100;

    always_comb begin
        if (s1_rest >= 14'd100) begin
            n_s1_hund = s1_qest + 7'd1;
            n_s1_hrem = 7'(s1_rest - 14'd100);
        end else begin
            n_s1_hund = s1_qest;
            n_s1_hrem = 7'(s1_rest);
        end
        n_s1_leap = (n_s1_hrem == 7'd0) ? (n_s1_hund[1:0] == 2'd0)
                                        : (n_s1_year[1:0] == 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_s1_year  <= n_s1_year;
            r_s1_month <= n_s1_month;
            r_s1_day   <= i_day;
            r_s1_off   <= i_day_offset;
            r_s1_hund  <= n_s1_hund;
            r_s1_hrem  <= n_s1_hrem;
            r_s1_leap  <= n_s1_leap;
        end
    end

    // Stage 2: month length, clamped day, ordinal day and partial day count
    logic [MLEN_W-1:0]          n_s2_mlen, r_s2_mlen;
    logic [DAY_W-1:0]           s2_day;
    logic                       s2_early;
    logic [YEAR_W-1:0]          s2_yy;
    logic [MONTH_W-1:0]         s2_mp;
    logic [YDAY_W-1:0]          s2_doym;
    logic [YDAY_W-1:0]          n_s2_yday, r_s2_yday;
    logic [6:0]                 n_s2_hund, r_s2_hund;
    logic [CNT_W-1:0]           n_s2_part, r_s2_part;
    logic signed [OFFSET_W-1:0] r_s2_off;
    logic                       r_s2_leap;

    always_comb begin
        n_s2_mlen = month_len(r_s1_month, r_s1_leap);
        if (r_s1_day == 5'd0) begin
            s2_day = 5'd1;
        end else if (r_s1_day > n_s2_mlen) begin
            s2_day = n_s2_mlen;
        end else begin
            s2_day = r_s1_day;
        end
        s2_early  = (r_s1_month <= MON_FEB);
        n_s2_yday = days_before(r_s1_month) + 9'(s2_day) + 9'(!s2_early && r_s1_leap);
        // Years counted from March, shifted up by one era
        s2_yy     = r_s1_year + (s2_early ? 14'd399 : 14'd400);
        n_s2_hund = r_s1_hund + 7'd4 - 7'(s2_early && (r_s1_hrem == 7'd0));
        s2_mp     = s2_early ? (r_s1_month + 4'd9) : (r_s1_month - 4'd3);
        s2_doym   = mar_cum(s2_mp) + 9'(s2_day) - 9'd1;
        n_s2_part = 22'(s2_yy) * 22'd365 + 22'(s2_yy >> 2) + 22'(s2_doym);
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_s2_mlen <= n_s2_mlen;
            r_s2_yday <= n_s2_yday;
            r_s2_hund <= n_s2_hund;
            r_s2_part <= n_s2_part;
            r_s2_off  <= r_s1_off;
            r_s2_leap <= r_s1_leap;
        end
    end

    // Stage 3: full day count, epoch days, weekday, shifted and clamped count
    logic [CNT_W-1:0]   s3_cnt;
    logic signed [23:0] s3_sum;
    logic [5:0]         s3_dsum;
    logic [3:0]         s3_fold;
    logic [CNT_W-1:0]   n_s3_count, r_s3_count;
    logic               n_s3_oor, r_s3_oor;
    t_date_info         n_s3_info, r_s3_info;

    assign s3_cnt = r_s2_part - 22'(r_s2_hund) + 22'(r_s2_hund >> 2);
    assign s3_sum = $signed({2'b00, s3_cnt})
                  + $signed({{(24 - OFFSET_W){r_s2_off[OFFSET_W-1]}}, r_s2_off});

    // Weekday is (count + 3) mod 7; base-8 digits sum to the same residue.
    always_comb begin
        s3_dsum = 6'd3 + 6'(s3_cnt[CNT_W-1]);
        for (int k = 0; k < 7; k++) begin
            s3_dsum = s3_dsum + 6'(s3_cnt[3*k +: 3]);
        end
        s3_fold = 4'(s3_dsum[5:3]) + 4'(s3_dsum[2:0]);
    end

    always_comb begin
        if (s3_sum < $signed({2'b00, CNT_MIN})) begin
            n_s3_count = CNT_MIN;
            n_s3_oor   = 1'b1;
        end else if (s3_sum > $signed({2'b00, CNT_MAX})) begin
            n_s3_count = CNT_MAX;
            n_s3_oor   = 1'b1;
        end else begin
            n_s3_count = s3_sum[CNT_W-1:0];
            n_s3_oor   = 1'b0;
        end
        n_s3_info.epoch_days   = $signed({1'b0, s3_cnt} - EPOCH_BIAS);
        n_s3_info.weekday      = (s3_fold >= 4'd7) ? 3'(s3_fold - 4'd7) : 3'(s3_fold);
        n_s3_info.year_day     = r_s2_yday;
        n_s3_info.leap_year    = r_s2_leap;
        n_s3_info.month_length = r_s2_mlen;
    end

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_s3_count <= n_s3_count;
            r_s3_oor   <= n_s3_oor;
            r_s3_info  <= n_s3_info;
        end
    end

    assign o_count        = r_s3_count;
    assign o_out_of_range = r_s3_oor;
    assign o_info         = r_s3_info;

endmodule

@@ rtl/gda_inv.sv @@
// Day count to date: five pipeline stages that split the biased count into
// era, day of era, year of era, day of year and finally month and day.
// Depends on gda_pkg.
module gda_inv
    import gda_pkg::*;
(
    input  logic             i_clk,
    input  logic [4:0]       i_load,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_out_of_range,
    input  t_date_info       i_info,
    output t_shift_date      o_shift,
    output t_date_info       o_info
);

    // Stage 4: era = count / 146097 by reciprocal estimate and one correction
    logic [26:0]      s4_prod;
    logic [4:0]       s4_eest;
    logic [CNT_W-1:0] s4_rest;
    logic [4:0]       n_s4_era, r_s4_era;
    logic [17:0]      n_s4_doe, r_s4_doe;
    logic             r_s4_oor;
    t_date_info       r_s4_info;

    assign s4_prod = 27'(i_count) * 27'd28;
    assign s4_eest = s4_prod[26:22];
    assign s4_rest = i_count - 22'(s4_eest) * ERA_DAYS;

    always_comb begin
        if (s4_rest >= ERA_DAYS) begin
            n_s4_era = s4_eest + 5'd1;
            n_s4_doe = 18'(s4_rest - ERA_DAYS);
        end else begin
            n_s4_era = s4_eest;
            n_s4_doe = 18'(s4_rest);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_s4_era  <= n_s4_era;
            r_s4_doe  <= n_s4_doe;
            r_s4_oor  <= i_out_of_range;
            r_s4_info <= i_info;
        end
    end

    // Stage 5: remove leap days from the day of era
    logic [25:0] s5_prod;
    logic [6:0]  s5_aest;
    logic [17:0] s5_rest;
    logic [6:0]  s5_quad;
    logic [2:0]  s5_cent;
    logic        s5_last;
    logic [17:0] n_s5_x, r_s5_x;
    logic [17:0] r_s5_doe;
    logic [4:0]  r_s5_era;
    logic        r_s5_oor;
    t_date_info  r_s5_info;

    assign s5_prod = 26'(r_s4_doe) * 26'd179;
    assign s5_aest = s5_prod[24:18];
    assign s5_rest = r_s4_doe - 18'(s5_aest) * 18'd1460;

    always_comb begin
        s5_quad = (s5_rest >= 18'd1460) ? (s5_aest + 7'd1) : s5_aest;
        s5_cent = 3'(r_s4_doe >= 18'd36524) + 3'(r_s4_doe >= 18'd73048)
                + 3'(r_s4_doe >= 18'd109572) + 3'(r_s4_doe >= 18'd146096);
        s5_last = (r_s4_doe == 18'd146096);
        n_s5_x  = r_s4_doe - 18'(s5_quad) + 18'(s5_cent) - 18'(s5_last);
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_s5_x    <= n_s5_x;
            r_s5_doe  <= r_s4_doe;
            r_s5_era  <= r_s4_era;
            r_s5_oor  <= r_s4_oor;
            r_s5_info <= r_s4_info;
        end
    end

    // Stage 6: year of era = x / 365
    logic [27:0] s6_prod;
    logic [8:0]  s6_yest;
    logic [17:0] s6_rest;
    logic [8:0]  n_s6_yoe, r_s6_yoe;
    logic [17:0] r_s6_doe;
    logic [4:0]  r_s6_era;
    logic        r_s6_oor;
    t_date_info  r_s6_info;

    assign s6_prod  = 28'(r_s5_x) * 28'd718;
    assign s6_yest  = s6_prod[26:18];
    assign s6_rest  = r_s5_x - 18'(s6_yest) * 18'd365;
    assign n_s6_yoe = (s6_rest >= 18'd365) ? (s6_yest + 9'd1) : s6_yest;

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_s6_yoe  <= n_s6_yoe;
            r_s6_doe  <= r_s5_doe;
            r_s6_era  <= r_s5_era;
            r_s6_oor  <= r_s5_oor;
            r_s6_info <= r_s5_info;
        end
    end

    // Stage 7: day of the March-based year and the March-based year number
    logic [1:0]        s7_cent;
    logic [17:0]       s7_ystart;
    logic [YDAY_W-1:0] n_s7_doy, r_s7_doy;
    logic [YEAR_W-1:0] n_s7_yr, r_s7_yr;
    logic              r_s7_oor;
    t_date_info        r_s7_info;

    always_comb begin
        s7_cent   = 2'(r_s6_yoe >= 9'd100) + 2'(r_s6_yoe >= 9'd200)
                  + 2'(r_s6_yoe >= 9'd300);
        s7_ystart = 18'(r_s6_yoe) * 18'd365 + 18'(r_s6_yoe >> 2) - 18'(s7_cent);
        n_s7_doy  = 9'(r_s6_doe - s7_ystart);
        n_s7_yr   = 14'(r_s6_yoe) + 14'(r_s6_era) * 14'd400;
    end

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r_s7_doy  <= n_s7_doy;
            r_s7_yr   <= n_s7_yr;
            r_s7_oor  <= r_s6_oor;
            r_s7_info <= r_s6_info;
        end
    end

    // Stage 8: month by comparing against month starts, then day and year
    logic [MONTH_W-1:0] s8_mp;
    t_shift_date        n_s8_shift, r_s8_shift;
    t_date_info         r_s8_info;

    always_comb begin
        s8_mp = '0;
        for (int k = 1; k < MONTHS; k++) begin
            s8_mp = s8_mp + 4'(r_s7_doy >= mar_cum(4'(k)));
        end
        n_s8_shift.day          = 5'(r_s7_doy - mar_cum(s8_mp) + 9'd1);
        n_s8_shift.month        = (s8_mp < 4'd10) ? (s8_mp + 4'd3) : (s8_mp - 4'd9);
        n_s8_shift.year         = r_s7_yr + 14'(n_s8_shift.month <= MON_FEB) - 14'd400;
        n_s8_shift.out_of_range = r_s7_oor;
    end

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r_s8_shift <= n_s8_shift;
            r_s8_info  <= r_s7_info;
        end
    end

    assign o_shift = r_s8_shift;
    assign o_info  = r_s8_info;

endmodule

@@ rtl/gregorian_date_arithmetic.sv @@
// Top level of the Gregorian date unit: input register, stage valid chain,
// and the two conversion halves. Depends on gda_pkg, gda_fwd and gda_inv.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         i_in_valid / o_in_ready    year, month, day, day_offset
//   output   out        o_out_valid / i_out_ready  epoch_days .. out_of_range
//
// One word enters per cycle unless a full pipeline is held by a stalled output.
// The pipeline has nine stages: input register, three date to count stages,
// five count to date stages (the last is the output register).
// Each stage advances on its own when it is empty or the next stage moves, so
// bubbles close up while the output word waits to be taken.
// Reset is synchronous and clears only the stage valid bits.
module gregorian_date_arithmetic
    import gda_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [YEAR_W-1:0]          i_year,
    input  logic [MONTH_W-1:0]         i_month,
    input  logic [DAY_W-1:0]           i_day,
    input  logic signed [OFFSET_W-1:0] i_day_offset,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [EPOCH_W-1:0]  o_epoch_days,
    output logic [WDAY_W-1:0]          o_weekday,
    output logic [YDAY_W-1:0]          o_year_day,
    output logic                       o_leap_year,
    output logic [MLEN_W-1:0]          o_month_length,
    output logic [YEAR_W-1:0]          o_shifted_year,
    output logic [MONTH_W-1:0]         o_shifted_month,
    output logic [DAY_W-1:0]           o_shifted_day,
    output logic                       o_out_of_range
);

    localparam int unsigned NUM_STAGES = 9;

    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] n_vld, r_vld;

    // A stage loads when it is empty or its word moves on
    always_comb begin
        load[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            load[k] = !r_vld[k] || load[k+1];
        end
    end

    // The first stage takes the input valid, the others the valid before them.
    always_comb begin
        n_vld[0] = load[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_vld[k] = load[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Input register
    logic [YEAR_W-1:0]          r_s0_year;
    logic [MONTH_W-1:0]         r_s0_month;
    logic [DAY_W-1:0]           r_s0_day;
    logic signed [OFFSET_W-1:0] r_s0_off;

    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r_s0_year  <= i_year;
            r_s0_month <= i_month;
            r_s0_day   <= i_day;
            r_s0_off   <= i_day_offset;
        end
    end

    // Date to biased day count
    logic [CNT_W-1:0] fwd_count;
    logic             fwd_oor;
    t_date_info       fwd_info;

    gda_fwd u_fwd (
        .i_clk          (i_clk),
        .i_load         (load[3:1]),
        .i_year         (r_s0_year),
        .i_month        (r_s0_month),
        .i_day          (r_s0_day),
        .i_day_offset   (r_s0_off),
        .o_count        (fwd_count),
        .o_out_of_range (fwd_oor),
        .o_info         (fwd_info)
    );

    // Biased day count back to a calendar date
    t_shift_date inv_shift;
    t_date_info  inv_info;

    gda_inv u_inv (
        .i_clk          (i_clk),
        .i_load         (load[8:4]),
        .i_count        (fwd_count),
        .i_out_of_range (fwd_oor),
        .i_info         (fwd_info),
        .o_shift        (inv_shift),
        .o_info         (inv_info)
    );

    assign o_in_ready      = load[0];
    assign o_out_valid     = r_vld[NUM_STAGES-1];
    assign o_epoch_days    = inv_info.epoch_days;
    assign o_weekday       = inv_info.weekday;
    assign o_year_day      = inv_info.year_day;
    assign o_leap_year     = inv_info.leap_year;
    assign o_month_length  = inv_info.month_length;
    assign o_shifted_year  = inv_shift.year;
    assign o_shifted_month = inv_shift.month;
    assign o_shifted_day   = inv_shift.day;
    assign o_out_of_range  = inv_shift.out_of_range;

`ifndef ASSERT_OFF
    // An empty input register always takes a new word.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> o_in_ready)
        else $error("input register empty but not ready");

    // Weekday stays within a week.
    a_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_weekday <= 3'd6))
        else $error("weekday out of range");

    // Day 366 and a 29-day month only occur in leap years.
    a_leap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_year_day == 9'd366) || (o_month_length == 5'd29))
        |-> o_leap_year)
        else $error("leap-only day without leap year");

    // Shifted month and day are a plausible calendar position.
    a_shift_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_shifted_month >= MON_JAN) && (o_shifted_month <= MON_DEC)
                        && (o_shifted_day >= 5'd1))
        else $error("shifted date malformed");

    // A saturated shift lands on the first or last representable day.
    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |->
        ((o_shifted_year == 14'd0) && (o_shifted_month == MON_JAN) && (o_shifted_day == 5'd1))
        || ((o_shifted_year == YEAR_MAX) && (o_shifted_month == MON_DEC)
            && (o_shifted_day == 5'd31)))
        else $error("saturated date not at range end");
`endif

endmodule

@@ test/date_result_checker.sv @@
// Checker for the Gregorian date unit: watches both channels, predicts each result word
// from the accepted input word and compares field by field in arrival order.
// Depends on gda_pkg for field widths and the result structs.
module date_result_checker
    import gda_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [YEAR_W-1:0]          i_year,
    input  logic [MONTH_W-1:0]         i_month,
    input  logic [DAY_W-1:0]           i_day,
    input  logic signed [OFFSET_W-1:0] i_day_offset,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [EPOCH_W-1:0]  i_epoch_days,
    input  logic [WDAY_W-1:0]          i_weekday,
    input  logic [YDAY_W-1:0]          i_year_day,
    input  logic                       i_leap_year,
    input  logic [MLEN_W-1:0]          i_month_length,
    input  logic [YEAR_W-1:0]          i_shifted_year,
    input  logic [MONTH_W-1:0]         i_shifted_month,
    input  logic [DAY_W-1:0]           i_shifted_day,
    input  logic                       i_out_of_range,
    output int                         o_fail_count,
    output int                         o_pending
);

    // Calendar limits in days relative to 1970-01-01.
    localparam longint FIRST_DAY = -719528;
    localparam longint LAST_DAY  = 2932896;
    localparam longint ERA_LEN   = 146097;
    localparam longint MAR_BIAS  = 719468;

    localparam int unsigned MON_LEN_TAB [1:12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        t_date_info  info;
        t_shift_date shifted;
    } t_date_result;

    t_date_result expected_dates [$];
    t_date_result oldest;
    int           fails = 0;

    // Computes the full result word for one input word.
    function automatic t_date_result predict_date(input logic [YEAR_W-1:0] yr_in,
                                                  input logic [MONTH_W-1:0] mo_in,
                                                  input logic [DAY_W-1:0] dy_in,
                                                  input logic signed [OFFSET_W-1:0] off_in);
        longint y, m, d, len, ydays, adj, era, yoe, mp, doy, doe, days, t, z, sy, sm, sd;
        bit leap, clipped;
        t_date_result r;

        // Fields outside the calendar are clamped to the nearest valid value.
        y = (yr_in > YEAR_MAX) ? longint'(YEAR_MAX) : longint'(yr_in);
        m = (mo_in < 1) ? 1 : ((mo_in > 12) ? 12 : longint'(mo_in));
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        len = MON_LEN_TAB[m];
        if (m == 2 && leap) begin
            len = 29;
        end
        d = (dy_in < 1) ? 1 : ((dy_in > len) ? len : longint'(dy_in));

        // Date to day count, with years counted from March over 400-year eras.
        adj = y + 400 - ((m <= 2) ? 1 : 0);
        era = adj / 400;
        yoe = adj - era * 400;
        mp = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * ERA_LEN + doe - MAR_BIAS - ERA_LEN;

        ydays = d + ((m > 2 && leap) ? 1 : 0);
        for (int k = 1; k < m; k++) begin
            ydays += MON_LEN_TAB[k];
        end

        // Shift and saturate to years 0 through 9999.
        t = days + longint'(off_in);
        clipped = 1'b0;
        if (t < FIRST_DAY) begin
            t = FIRST_DAY;
            clipped = 1'b1;
        end
        if (t > LAST_DAY) begin
            t = LAST_DAY;
            clipped = 1'b1;
        end

        // Day count back to a calendar date.
        z = t + MAR_BIAS + ERA_LEN;
        era = z / ERA_LEN;
        doe = z - era * ERA_LEN;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        sd = doy - (153 * mp + 2) / 5 + 1;
        sm = (mp < 10) ? mp + 3 : mp - 9;
        sy = yoe + era * 400 + ((sm <= 2) ? 1 : 0) - 400;

        r.info.epoch_days      = EPOCH_W'(days);
        r.info.weekday         = WDAY_W'(((days % 7) + 11) % 7);
        r.info.year_day        = YDAY_W'(ydays);
        r.info.leap_year       = leap;
        r.info.month_length    = MLEN_W'(len);
        r.shifted.year         = YEAR_W'(sy);
        r.shifted.month        = MONTH_W'(sm);
        r.shifted.day          = DAY_W'(sd);
        r.shifted.out_of_range = clipped;
        return r;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(input string what, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fails++;
        end
    endtask

    // Predict on every accepted input word, compare on every accepted result word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                expected_dates.push_back(predict_date(i_year, i_month, i_day, i_day_offset));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_dates.size() == 0) begin
                    $display("%0t: extra result word, expected none, actual epoch_days %0d",
                             $time, i_epoch_days);
                    fails++;
                end else begin
                    oldest = expected_dates.pop_front();
                    check_field("epoch_days", $signed(oldest.info.epoch_days),
                                $signed(i_epoch_days));
                    check_field("weekday", oldest.info.weekday, i_weekday);
                    check_field("year_day", oldest.info.year_day, i_year_day);
                    check_field("leap_year", oldest.info.leap_year, i_leap_year);
                    check_field("month_length", oldest.info.month_length, i_month_length);
                    check_field("shifted_year", oldest.shifted.year, i_shifted_year);
                    check_field("shifted_month", oldest.shifted.month, i_shifted_month);
                    check_field("shifted_day", oldest.shifted.day, i_shifted_day);
                    check_field("out_of_range", oldest.shifted.out_of_range, i_out_of_range);
                end
            end
        end
        o_pending    <= expected_dates.size();
        o_fail_count <= fails;
    end

endmodule

@@ test/testbench.sv @@
// Top of the Gregorian date unit testbench: clock, reset, stimulus in idling phases and
// the verdict. Depends on gda_pkg, gregorian_date_arithmetic and date_result_checker.
module testbench;
    import gda_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int WORDS_PER_PHASE = 212;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [YEAR_W-1:0]          i_year = '0;
    logic [MONTH_W-1:0]         i_month = MON_JAN;
    logic [DAY_W-1:0]           i_day = 5'd1;
    logic signed [OFFSET_W-1:0] i_day_offset = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [EPOCH_W-1:0]  o_epoch_days;
    logic [WDAY_W-1:0]          o_weekday;
    logic [YDAY_W-1:0]          o_year_day;
    logic                       o_leap_year;
    logic [MLEN_W-1:0]          o_month_length;
    logic [YEAR_W-1:0]          o_shifted_year;
    logic [MONTH_W-1:0]         o_shifted_month;
    logic [DAY_W-1:0]           o_shifted_day;
    logic                       o_out_of_range;

    int fail_count;
    int pending_words;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    gregorian_date_arithmetic dut (.*);

    date_result_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_year          (i_year),
        .i_month         (i_month),
        .i_day           (i_day),
        .i_day_offset    (i_day_offset),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_epoch_days    (o_epoch_days),
        .i_weekday       (o_weekday),
        .i_year_day      (o_year_day),
        .i_leap_year     (o_leap_year),
        .i_month_length  (o_month_length),
        .i_shifted_year  (o_shifted_year),
        .i_shifted_month (o_shifted_month),
        .i_shifted_day   (o_shifted_day),
        .i_out_of_range  (o_out_of_range),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words)
    );

    always #1 i_clk = ~i_clk;

    // Receiver stalls at random according to the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offers one input word after a random gap and waits until it is taken.
    task automatic send_date(input int yr, input int mo, input int dy, input int off);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_year       <= YEAR_W'(yr);
        i_month      <= MONTH_W'(mo);
        i_day        <= DAY_W'(dy);
        i_day_offset <= OFFSET_W'(off);
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Holds the input side idle until every predicted word has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_words != 0);
    endtask

    // Random word: mostly valid dates with offsets of every scale, some raw noise.
    task automatic send_random_date();
        int yr, mo, dy, off, kind;
        kind = $urandom_range(0, 9);
        yr = $urandom_range(0, 9999);
        mo = $urandom_range(1, 12);
        dy = $urandom_range(1, 28);
        case ($urandom_range(0, 3))
            0:       off = int'($urandom_range(0, 80)) - 40;
            1:       off = int'($urandom_range(0, 8000)) - 4000;
            2:       off = int'($urandom_range(0, 400000)) - 200000;
            default: off = int'($urandom);
        endcase
        if (kind == 6) begin
            // Near the ends of the calendar, where shifts saturate.
            yr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(9996, 9999);
            off = int'($urandom);
        end else if (kind == 7) begin
            yr = $urandom;
            mo = $urandom;
            dy = $urandom;
            off = int'($urandom);
        end else if (kind == 8) begin
            // Month and year boundaries, including days past the month end.
            case ($urandom_range(0, 3))
                0:       mo = 1;
                1:       mo = 2;
                2:       mo = 3;
                default: mo = 12;
            endcase
            case ($urandom_range(0, 4))
                0:       dy = 1;
                1:       dy = 28;
                2:       dy = 29;
                3:       dy = 30;
                default: dy = 31;
            endcase
            off = int'($urandom_range(0, 800)) - 400;
        end else if (kind == 9) begin
            dy = $urandom_range(1, 31);
        end
        send_date(yr, mo, dy, off);
    endtask

    // Cycle limit for the whole run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: calendar ends, clamped fields, leap rules, saturation.
        send_date(1970, 1, 1, 0);
        send_date(0, 1, 1, 0);
        send_date(0, 1, 1, -1);
        send_date(9999, 12, 31, 0);
        send_date(9999, 12, 31, 1);
        send_date(16383, 15, 31, 1048575);
        send_date(0, 0, 0, -1048576);
        send_date(2000, 2, 29, 0);
        send_date(1900, 2, 29, 0);
        send_date(2100, 2, 29, 0);
        send_date(2024, 2, 31, 365);
        send_date(2023, 2, 28, 1);
        send_date(1600, 12, 31, -1048576);
        send_date(8000, 1, 1, 1048575);
        send_date(1969, 12, 31, 1);
        send_date(5000, 4, 31, -1);
        send_date(10000, 6, 15, 0);
        send_date(0, 13, 1, 0);
        send_date(1, 3, 1, -60);
        send_date(9999, 12, 31, -1048576);
        send_date(2, 5, 10, -800);
        send_date(7000, 9, 30, 0);
        send_date(4, 2, 29, 366);
        drain_results();

        // Random words in four idling phases, drained in between.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 72;
                end
                default: begin
                    send_idle_pct = 14;
                    recv_stall_pct = 14;
                end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                send_random_date();
            end
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
